/* rtl/core/lps_pkg.sv */
`timescale 1ns / 1ps

package lps_pkg;

    localparam int TIME_BITS = 16;
    localparam int CfgW      = 16;
    localparam int PtW       = 17;
    localparam int CmpW      = (TIME_BITS > PtW) ? TIME_BITS : PtW;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_CYCLE = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_DONE  = 3'd1,
        ST_SKIP  = 3'd2,
        ST_LEVEL = 3'd3,
        ST_PRESS = 3'd4,
        ST_RETRY = 3'd5
    } status_t;

    localparam logic [2:0] MODE_TIME = 3'd0;
    localparam logic [2:0] MODE_AND  = 3'd1;
    localparam logic [2:0] MODE_OR_A = 3'd2;
    localparam logic [2:0] MODE_OR_B = 3'd3;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_MODE       = 3'd1;
    localparam logic [2:0] REG_INTERVAL   = 3'd2;
    localparam logic [2:0] REG_PULSE      = 3'd3;
    localparam logic [2:0] REG_PAUSE      = 3'd4;
    localparam logic [2:0] REG_TOTAL      = 3'd5;
    localparam logic [2:0] REG_LEVEL_LOW  = 3'd6;
    localparam logic [2:0] REG_RETRY      = 3'd7;

    typedef struct packed {
        logic            enable;
        logic [2:0]      mode;
        logic [CfgW-1:0] cycle_interval;
        logic [CfgW-1:0] pulse_time;
        logic [CfgW-1:0] pause_time;
        logic [CfgW-1:0] total_time;
        logic            level_active_low;
        logic            retry_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] lub_count;
        logic        auto_mode;
        logic        level_input;
        logic        pressure_ok;
    } item_t;

    typedef struct packed {
        logic        alarm_first;
        logic [2:0]  status;
        logic        busy_res;
        logic [15:0] cycles_left;
        logic        need;
        logic        valve_on;
    } result_t;

    function automatic time_t sat_inc(time_t v);
        return (v == '1) ? v : time_t'(v + 1'b1);
    endfunction

endpackage

/* rtl/core/lps_cfg.sv */
`timescale 1ns / 1ps

module lps_cfg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    output lps_pkg::cfg_t           cfg
);

    lps_pkg::cfg_t cfg_reg;
    lps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lps_pkg::REG_ENABLE:    cfg_next.enable           = cfg_data[0];
                lps_pkg::REG_MODE:      cfg_next.mode             = cfg_data[2:0];
                lps_pkg::REG_INTERVAL:  cfg_next.cycle_interval   = cfg_data;
                lps_pkg::REG_PULSE:     cfg_next.pulse_time       = cfg_data;
                lps_pkg::REG_PAUSE:     cfg_next.pause_time       = cfg_data;
                lps_pkg::REG_TOTAL:     cfg_next.total_time       = cfg_data;
                lps_pkg::REG_LEVEL_LOW: cfg_next.level_active_low = cfg_data[0];
                lps_pkg::REG_RETRY:     cfg_next.retry_enable     = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/lps_seq.sv */
`timescale 1ns / 1ps

module lps_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  lps_pkg::cfg_t    cfg,
    input  logic             step_en,
    input  lps_pkg::item_t   item,
    output lps_pkg::result_t result
);

    lps_pkg::phase_t             phase_reg, phase_next;
    lps_pkg::time_t              step_reg, step_next;
    lps_pkg::time_t              run_reg, run_next;
    logic [lps_pkg::PtW-1:0]     target_reg, target_next;
    logic [15:0]                 count_reg, count_next;
    logic [15:0]                 left_reg, left_next;
    logic                        need_reg, need_next;
    logic                        retry_reg, retry_next;
    logic                        valve_reg, valve_next;
    logic                        alarm_reg, alarm_next;
    lps_pkg::status_t            st;

    always_comb begin
        lps_pkg::time_t   step_n;
        lps_pkg::time_t   run_n;
        logic             timed;
        logic             ormode;
        logic             level_err;
        logic [16:0]      cnt_inc;
        logic [15:0]      cnt_clamp;

        phase_next  = phase_reg;
        step_next   = step_reg;
        run_next    = run_reg;
        target_next = target_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        need_next   = need_reg;
        retry_next  = retry_reg;
        valve_next  = valve_reg;
        alarm_next  = alarm_reg;
        st          = lps_pkg::ST_NONE;

        step_n    = lps_pkg::sat_inc(step_reg);
        run_n     = lps_pkg::sat_inc(run_reg);
        timed     = lps_pkg::CmpW'(step_n) >= lps_pkg::CmpW'(cfg.pulse_time);
        ormode    = (cfg.mode == lps_pkg::MODE_OR_A) || (cfg.mode == lps_pkg::MODE_OR_B);
        level_err = cfg.level_active_low ? !item.level_input : item.level_input;
        cnt_inc   = {1'b0, count_reg} + 17'd1;
        cnt_clamp = (cnt_inc > {1'b0, cfg.cycle_interval}) ? cfg.cycle_interval
                                                            : cnt_inc[15:0];

        case (lps_pkg::action_t'(item.action))
            lps_pkg::ACT_TICK: begin
                if (phase_reg != lps_pkg::PH_IDLE) begin
                    step_next = step_n;
                    run_next  = run_n;
                    if (phase_reg == lps_pkg::PH_PULSE) begin
                        if (cfg.mode == lps_pkg::MODE_TIME) begin
                            if (timed) begin
                                valve_next = 1'b0;
                                retry_next = 1'b0;
                                alarm_next = 1'b0;
                                phase_next = lps_pkg::PH_IDLE;
                                st         = lps_pkg::ST_DONE;
                            end
                        end else if (cfg.mode <= lps_pkg::MODE_OR_B && timed) begin
                            if (item.pressure_ok) begin
                                valve_next  = 1'b0;
                                phase_next  = lps_pkg::PH_PAUSE;
                                target_next = lps_pkg::PtW'(cfg.pause_time);
                                step_next   = '0;
                            end else if (cfg.retry_enable && !retry_reg) begin
                                retry_next = 1'b1;
                                valve_next = 1'b0;
                                phase_next = lps_pkg::PH_IDLE;
                                st         = lps_pkg::ST_RETRY;
                            end else begin
                                retry_next = 1'b0;
                                valve_next = 1'b0;
                                alarm_next = 1'b1;
                                phase_next = lps_pkg::PH_IDLE;
                                st         = lps_pkg::ST_PRESS;
                            end
                        end else if (ormode && item.pressure_ok) begin
                            // early confirm: leftover pulse time moves into the pause
                            valve_next  = 1'b0;
                            target_next = lps_pkg::PtW'(cfg.pause_time)
                                        + lps_pkg::PtW'(cfg.pulse_time)
                                        - lps_pkg::PtW'(step_n);
                            phase_next  = lps_pkg::PH_PAUSE;
                            step_next   = '0;
                        end else if (cfg.mode > lps_pkg::MODE_OR_B) begin
                            valve_next = 1'b0;
                            retry_next = 1'b0;
                            alarm_next = 1'b0;
                            phase_next = lps_pkg::PH_IDLE;
                            st         = lps_pkg::ST_DONE;
                        end
                    end else begin
                        if (lps_pkg::CmpW'(run_n) >= lps_pkg::CmpW'(cfg.total_time)) begin
                            valve_next = 1'b0;
                            retry_next = 1'b0;
                            alarm_next = 1'b0;
                            phase_next = lps_pkg::PH_IDLE;
                            st         = lps_pkg::ST_DONE;
                        end else if (lps_pkg::CmpW'(step_n) >= lps_pkg::CmpW'(target_reg)) begin
                            valve_next = 1'b1;
                            phase_next = lps_pkg::PH_PULSE;
                            step_next  = '0;
                        end
                    end
                end
            end
            lps_pkg::ACT_CYCLE: begin
                if (cfg.enable) begin
                    count_next = cnt_clamp;
                    left_next  = cfg.cycle_interval - cnt_clamp;
                    if (cfg.cycle_interval == '0 || cfg.cycle_interval == cnt_clamp ||
                        retry_reg || item.lub_count == '0) begin
                        count_next = '0;
                        need_next  = 1'b1;
                    end
                end else begin
                    left_next  = '0;
                    count_next = '0;
                    need_next  = 1'b0;
                end
            end
            lps_pkg::ACT_START: begin
                if (phase_reg == lps_pkg::PH_IDLE) begin
                    if (item.auto_mode && !need_reg) begin
                        st = lps_pkg::ST_SKIP;
                    end else if (level_err) begin
                        st = lps_pkg::ST_LEVEL;
                    end else begin
                        run_next   = '0;
                        step_next  = '0;
                        need_next  = 1'b0;
                        valve_next = (cfg.pulse_time != '0);
                        phase_next = lps_pkg::PH_PULSE;
                    end
                end
            end
            default: ;
        endcase
    end

    assign result.valve_on    = valve_next;
    assign result.need        = need_next;
    assign result.cycles_left = left_next;
    assign result.busy_res    = (phase_next != lps_pkg::PH_IDLE);
    assign result.status      = st;
    assign result.alarm_first = alarm_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= lps_pkg::PH_IDLE;
            step_reg   <= '0;
            run_reg    <= '0;
            target_reg <= '0;
            count_reg  <= '0;
            left_reg   <= '0;
            need_reg   <= 1'b0;
            retry_reg  <= 1'b0;
            valve_reg  <= 1'b0;
            alarm_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            run_reg    <= run_next;
            target_reg <= target_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            need_reg   <= need_next;
            retry_reg  <= retry_next;
            valve_reg  <= valve_next;
            alarm_reg  <= alarm_next;
        end
    end

endmodule

/* rtl/core/lubrication_pump_sequencer.sv */
`timescale 1ns / 1ps
// Lubrication pump sequencer.
// Input words on s_t*: tuser is the action (0 tick of 10 ms, 1 machine
// cycle done, 2 start request); tdata carries the count and sensor bits.
// Every input word gives exactly one result word on m_t*: valve drive,
// need flag, cycles left, busy, event status and alarm.
// Settings are written through cfg_valid/cfg_index/cfg_data (always ready)
// and are to be changed only while no word is in flight.
// A word accepted into the input register moves into the result register, with
// m_tvalid high, as soon as that register is free (input register, then result
// register). Throughput is one word per cycle while the receiver keeps taking
// results; the combinational state update is the only path per word.
// When the receiver holds m_tready low the result register holds its word,
// the input register still takes one more word if it is empty, then s_tready drops.
// Reset (aresetn low, synchronous) clears all settings, the sequence state,
// counters and flags, and empties both registers.
module lubrication_pump_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // action
    input  logic [23:0] s_tdata,   // lub_count[15:0], auto_mode, level_input, pressure_ok, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // valve_on, need, cycles_left[15:0], busy_res, status[2:0],
                                   // alarm_first, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lps_pkg::cfg_t    cfg;
    lps_pkg::item_t   in_reg;
    lps_pkg::result_t res_next;
    lps_pkg::result_t res_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    lps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lps_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .item    (in_reg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.action      <= s_tuser;
            in_reg.lub_count   <= s_tdata[15:0];
            in_reg.auto_mode   <= s_tdata[16];
            in_reg.level_input <= s_tdata[17];
            in_reg.pressure_ok <= s_tdata[18];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

/* test/lubrication_pump_sequencer_tb.sv */
`timescale 1ns / 1ps

module lubrication_pump_sequencer_tb;

    import lps_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // action
    logic [23:0] s_tdata;   // lub_count[15:0], auto_mode, level_input, pressure_ok, pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // valve_on, need, cycles_left[15:0], busy_res, status[2:0],
                            // alarm_first, pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    lubrication_pump_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sequencer model state
    cfg_t        lube_cfg     = '0;
    phase_t      seq_phase    = PH_IDLE;
    time_t       step_count   = '0;
    time_t       run_count    = '0;
    logic [16:0] pause_goal   = '0;
    logic [15:0] cycle_count  = '0;
    logic [15:0] cycles_held  = '0;
    logic        need_flag    = 1'b0;
    logic        retry_flag   = 1'b0;
    logic        valve_flag   = 1'b0;
    logic        alarm_flag   = 1'b0;

    result_t     lube_results_q[$];
    result_t     got_word;
    result_t     want_word;
    int          mismatches    = 0;
    int          rx_hold_cycles = 0;
    bit          idle_on       = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic status_t close_sequence();
        valve_flag = 1'b0;
        retry_flag = 1'b0;
        alarm_flag = 1'b0;
        seq_phase  = PH_IDLE;
        return ST_DONE;
    endfunction

    function automatic result_t advance_sequencer(item_t it);
        status_t     st;
        logic        timed;
        logic [16:0] nxt;
        result_t     r;
        st = ST_NONE;
        case (it.action)
            ACT_TICK: begin
                if (seq_phase != PH_IDLE) begin
                    step_count = (step_count == '1) ? step_count : step_count + 1'b1;
                    run_count  = (run_count == '1) ? run_count : run_count + 1'b1;
                    if (seq_phase == PH_PULSE) begin
                        timed = (step_count >= lube_cfg.pulse_time);
                        if (lube_cfg.mode == MODE_TIME) begin
                            if (timed) st = close_sequence();
                        end else if (lube_cfg.mode <= MODE_OR_B && timed) begin
                            if (it.pressure_ok) begin
                                valve_flag = 1'b0;
                                seq_phase  = PH_PAUSE;
                                pause_goal = {1'b0, lube_cfg.pause_time};
                                step_count = '0;
                            end else if (lube_cfg.retry_enable && !retry_flag) begin
                                retry_flag = 1'b1;
                                valve_flag = 1'b0;
                                seq_phase  = PH_IDLE;
                                st = ST_RETRY;
                            end else begin
                                retry_flag = 1'b0;
                                valve_flag = 1'b0;
                                alarm_flag = 1'b1;
                                seq_phase  = PH_IDLE;
                                st = ST_PRESS;
                            end
                        end else if ((lube_cfg.mode == MODE_OR_A || lube_cfg.mode == MODE_OR_B)
                                     && it.pressure_ok) begin
                            // early confirm: remaining pulse time moves into the pause
                            valve_flag = 1'b0;
                            pause_goal = 17'(lube_cfg.pause_time) + 17'(lube_cfg.pulse_time)
                                         - 17'(step_count);
                            seq_phase  = PH_PAUSE;
                            step_count = '0;
                        end else if (lube_cfg.mode > MODE_OR_B) begin
                            st = close_sequence();
                        end
                    end else begin
                        if (run_count >= lube_cfg.total_time) begin
                            st = close_sequence();
                        end else if (17'(step_count) >= pause_goal) begin
                            valve_flag = 1'b1;
                            seq_phase  = PH_PULSE;
                            step_count = '0;
                        end
                    end
                end
            end
            ACT_CYCLE: begin
                if (lube_cfg.enable) begin
                    nxt = 17'(cycle_count) + 17'd1;
                    if (nxt > 17'(lube_cfg.cycle_interval)) nxt = 17'(lube_cfg.cycle_interval);
                    cycle_count = nxt[15:0];
                    cycles_held = lube_cfg.cycle_interval - cycle_count;
                    if (lube_cfg.cycle_interval == 16'd0 || cycles_held == 16'd0
                        || retry_flag || it.lub_count == 16'd0) begin
                        cycle_count = '0;
                        need_flag   = 1'b1;
                    end
                end else begin
                    cycles_held = '0;
                    cycle_count = '0;
                    need_flag   = 1'b0;
                end
            end
            ACT_START: begin
                if (seq_phase == PH_IDLE) begin
                    if (it.auto_mode && !need_flag) begin
                        st = ST_SKIP;
                    end else if (lube_cfg.level_active_low ? !it.level_input
                                                           : it.level_input) begin
                        st = ST_LEVEL;
                    end else begin
                        run_count  = '0;
                        step_count = '0;
                        need_flag  = 1'b0;
                        valve_flag = (lube_cfg.pulse_time != 16'd0);
                        seq_phase  = PH_PULSE;
                    end
                end
            end
            default: begin
            end
        endcase
        r.valve_on    = valve_flag;
        r.need        = need_flag;
        r.cycles_left = cycles_held;
        r.busy_res    = (seq_phase != PH_IDLE);
        r.status      = st;
        r.alarm_first = alarm_flag;
        return r;
    endfunction

    function automatic item_t word_of(logic [1:0] act, logic [15:0] cnt, logic au,
                                      logic lv, logic pr);
        item_t it;
        it.action      = act;
        it.lub_count   = cnt;
        it.auto_mode   = au;
        it.level_input = lv;
        it.pressure_ok = pr;
        return it;
    endfunction

    function automatic item_t random_item(bit well_formed);
        item_t       it;
        int unsigned r;
        it.lub_count   = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        it.auto_mode   = 1'($urandom_range(0, 1));
        it.level_input = 1'($urandom_range(0, 1));
        it.pressure_ok = 1'($urandom_range(0, 1));
        if (well_formed) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                it.action = ACT_TICK;
            end else if (r < 80) begin
                it.action = ACT_CYCLE;
            end else begin
                it.action = ACT_START;
                if ($urandom_range(0, 5) != 0) it.level_input = lube_cfg.level_active_low;
            end
        end else begin
            it.action = 2'($urandom_range(0, 3));
        end
        return it;
    endfunction

    function automatic logic [15:0] random_span(int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, hi));
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.enable           = ($urandom_range(0, 7) != 0);
        c.mode             = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
                                                        : 3'($urandom_range(4, 7));
        c.cycle_interval   = random_span(6);
        c.pulse_time       = random_span(4);
        c.pause_time       = random_span(4);
        c.total_time       = random_span(24);
        c.level_active_low = 1'($urandom_range(0, 1));
        c.retry_enable     = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_word(item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {5'd0, it.pressure_ok, it.level_input, it.auto_mode, it.lub_count};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        lube_results_q.push_back(advance_sequencer(it));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (lube_results_q.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        case (idx)
            REG_ENABLE:    lube_cfg.enable           = val[0];
            REG_MODE:      lube_cfg.mode             = val[2:0];
            REG_INTERVAL:  lube_cfg.cycle_interval   = val;
            REG_PULSE:     lube_cfg.pulse_time       = val;
            REG_PAUSE:     lube_cfg.pause_time       = val;
            REG_TOTAL:     lube_cfg.total_time       = val;
            REG_LEVEL_LOW: lube_cfg.level_active_low = val[0];
            REG_RETRY:     lube_cfg.retry_enable     = val[0];
            default: begin
            end
        endcase
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_ENABLE,    {15'd0, c.enable});
        write_reg(REG_MODE,      {13'd0, c.mode});
        write_reg(REG_INTERVAL,  c.cycle_interval);
        write_reg(REG_PULSE,     c.pulse_time);
        write_reg(REG_PAUSE,     c.pause_time);
        write_reg(REG_TOTAL,     c.total_time);
        write_reg(REG_LEVEL_LOW, {15'd0, c.level_active_low});
        write_reg(REG_RETRY,     {15'd0, c.retry_enable});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_word(word_of(ACT_UNUSED, 16'h1234, 1'b1, 1'b1, 1'b1));
        send_word(word_of(ACT_TICK,   16'd0,    1'b0, 1'b0, 1'b1));
        send_word(word_of(ACT_CYCLE,  16'd5,    1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_START,  16'd0,    1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_TICK,   16'd0,    1'b0, 1'b0, 1'b0));
        wait_drained();
    endtask

    task automatic test_early_pressure();
        cfg_t c;
        c = '{enable: 1'b1, mode: MODE_OR_A, cycle_interval: 16'd2, pulse_time: 16'hFFFF,
              pause_time: 16'd0, total_time: 16'd2, level_active_low: 1'b1,
              retry_enable: 1'b1};
        load_config(c);
        send_word(word_of(ACT_CYCLE, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_CYCLE, 16'd1,    1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_START, 16'd0,    1'b1, 1'b0, 1'b0));
        send_word(word_of(ACT_START, 16'd0,    1'b1, 1'b1, 1'b0));
        send_word(word_of(ACT_START, 16'd0,    1'b0, 1'b1, 1'b0));
        send_word(word_of(ACT_TICK,  16'd0,    1'b0, 1'b0, 1'b1));
        send_word(word_of(ACT_TICK,  16'd0,    1'b0, 1'b0, 1'b0));
        wait_drained();
    endtask

    task automatic test_retry_and_alarm();
        cfg_t c;
        c = '{enable: 1'b1, mode: MODE_AND, cycle_interval: 16'hFFFF, pulse_time: 16'd1,
              pause_time: 16'd1, total_time: 16'hFFFF, level_active_low: 1'b1,
              retry_enable: 1'b1};
        load_config(c);
        send_word(word_of(ACT_CYCLE, 16'd0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_START, 16'd0, 1'b0, 1'b1, 1'b0));
        send_word(word_of(ACT_TICK,  16'd0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_CYCLE, 16'd7, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_START, 16'd0, 1'b1, 1'b1, 1'b0));
        send_word(word_of(ACT_TICK,  16'd0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_START, 16'd0, 1'b0, 1'b1, 1'b0));
        send_word(word_of(ACT_TICK,  16'd0, 1'b0, 1'b0, 1'b1));
        send_word(word_of(ACT_TICK,  16'd0, 1'b0, 1'b0, 1'b0));
        wait_drained();
    endtask

    task automatic test_clamp_and_bad_mode();
        cfg_t c;
        send_word(word_of(ACT_CYCLE, 16'd9, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_CYCLE, 16'd9, 1'b0, 1'b0, 1'b0));
        wait_drained();
        c = lube_cfg;
        c.cycle_interval = 16'd1;
        c.mode           = 3'd4;
        load_config(c);
        send_word(word_of(ACT_CYCLE, 16'd9, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_TICK,  16'd0, 1'b0, 1'b0, 1'b0));
        send_word(word_of(ACT_START, 16'd0, 1'b1, 1'b1, 1'b0));
        send_word(word_of(ACT_TICK,  16'd0, 1'b0, 1'b0, 1'b1));
        wait_drained();
    endtask

    task automatic test_random_sequences(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            wait_drained();
            load_config(random_config());
            repeat (per_phase) send_word(random_item($urandom_range(0, 9) != 0));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold_cycles = 60;
        repeat (12) send_word(random_item(1'b1));
        wait_drained();
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                while (rx_hold_cycles > 0) begin
                    @(posedge aclk);
                    rx_hold_cycles--;
                end
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word.valve_on    = m_tdata[0];
            got_word.need        = m_tdata[1];
            got_word.cycles_left = m_tdata[17:2];
            got_word.busy_res    = m_tdata[18];
            got_word.status      = m_tdata[21:19];
            got_word.alarm_first = m_tdata[22];
            if (lube_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing expected", $realtime);
            end else begin
                want_word = lube_results_q.pop_front();
                if (got_word.valve_on !== want_word.valve_on
                    || got_word.need !== want_word.need
                    || got_word.cycles_left !== want_word.cycles_left
                    || got_word.busy_res !== want_word.busy_res
                    || got_word.status !== want_word.status
                    || got_word.alarm_first !== want_word.alarm_first) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: exp valve=%0d need=%0d left=%0d busy=%0d st=%0d ",
                                  "alarm=%0d got valve=%0d need=%0d left=%0d busy=%0d ",
                                  "st=%0d alarm=%0d"}, $realtime,
                                 want_word.valve_on, want_word.need, want_word.cycles_left,
                                 want_word.busy_res, want_word.status, want_word.alarm_first,
                                 got_word.valve_on, got_word.need, got_word.cycles_left,
                                 got_word.busy_res, got_word.status, got_word.alarm_first);
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_early_pressure();
        test_retry_and_alarm();
        test_clamp_and_bad_mode();
        test_random_sequences(12, 20);
        test_backpressure();
        test_random_sequences(8, 20);
        idle_on = 1'b0;
        test_random_sequences(5, 20);

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && lube_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
